>>> rtl/core/dtrd_pkg.sv
// ----------------------------------------------------------------------------
// dtrd_pkg
// Shared constants and types for the disk transfer request decoder: command
// letters, acknowledge words, status codes and output field layout.
// ----------------------------------------------------------------------------
package dtrd_pkg;

  // Geometry of one disk side and of one page of memory.
  localparam int DISK_BLOCKS = 3248;
  localparam int PAGE_WORDS  = 128;
  localparam int PAGE_SHIFT  = $clog2(PAGE_WORDS);

  // Field widths.
  localparam int RX_W      = 8;
  localparam int HALF_W    = 6;
  localparam int WORD_W    = 12;
  localparam int BLOCK_W   = 13;
  localparam int COUNT_W   = 13;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 48;

  // Command letters that open a request.
  localparam logic [RX_W-1:0] CMD_A = 8'h41;
  localparam logic [RX_W-1:0] CMD_B = 8'h42;
  localparam logic [RX_W-1:0] CMD_C = 8'h43;
  localparam logic [RX_W-1:0] CMD_D = 8'h44;

  // Reply words.
  localparam logic [WORD_W-1:0] CDF_BASE     = 12'o6201;
  localparam logic [WORD_W-1:0] FIELD_MASK   = 12'o0070;
  localparam logic [WORD_W-1:0] ACK_RD       = 12'o4000;
  localparam logic [WORD_W-1:0] ACK_WR       = 12'o4001;
  localparam logic [WORD_W-1:0] NAK          = 12'o2000;
  localparam logic [WORD_W-1:0] NAK_PROTECT  = 12'o2020;
  localparam logic [WORD_W-1:0] NAK_PAST_END = 12'o2002;
  localparam logic [WORD_W-1:0] NAK_OVERLAP  = 12'o2004;

  // Start of the field-0 handler area.
  localparam logic [WORD_W-1:0] HANDLER_BASE = 12'o7600;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_DISK  = 3'd1,
    ST_PROTECT  = 3'd2,
    ST_PAST_END = 3'd3,
    ST_OVERLAP  = 3'd4
  } status_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PRESENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PRESENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RD_BLK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WR_BLK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RD_BLK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WR_BLK  = 3'd5;

  // Reply word slots.
  localparam logic [1:0] SLOT_CDF   = 2'd0;
  localparam logic [1:0] SLOT_COUNT = 2'd1;
  localparam logic [1:0] SLOT_ACK   = 2'd2;

endpackage

>>> rtl/core/disk_transfer_request_decoder.sv
// ----------------------------------------------------------------------------
// disk_transfer_request_decoder
// Decodes a serial disk request header and replies with CDF, count and ack.
// ----------------------------------------------------------------------------
// Latency: the first reply word is valid the cycle after the last header byte
// is accepted; the three reply words follow on consecutive cycles when taken.
// Throughput: one byte per cycle; a header closes only when the previous reply
// has drained, so a stalled reply holds back just the final header byte.
// Reset (rst_n low at a clock edge): the decoder waits for a command letter,
// the reply buffer is empty and the configuration returns to its defaults.
// ----------------------------------------------------------------------------
module disk_transfer_request_decoder
  import dtrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream. tdata: [7:0] rx_byte.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [RX_W-1:0]      in_tdata,
  // Reply stream. tdata: [11:0] tx_word, [12] is_write, [13] disk_select,
  // [26:14] first_block, [39:27] transfer_words, [40] pad_half_block,
  // [43:41] status, [47:44] zero. tlast: last_word.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tlast,
  // Configuration write port.
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  // Header phase: waiting for a command letter, then six word halves.
  typedef enum logic [2:0] {
    PH_CMD, PH_H1, PH_H2, PH_H3, PH_H4, PH_H5, PH_H6
  } phase_t;

  phase_t phase_r;
  logic   disk_r, side_r;
  logic [HALF_W-1:0] store_r [5];

  // Configuration registers.
  logic first_present_r, second_present_r;
  logic first_rd_blk_r, first_wr_blk_r, second_rd_blk_r, second_wr_blk_r;

  // Reply buffer: three words plus the descriptor carried on the last one.
  logic              out_valid_r;
  logic [1:0]        slot_r;
  logic [WORD_W-1:0] cdf_r, count_r, ack_r;
  logic              wr_r, pad_r;
  logic [BLOCK_W-1:0] first_block_r;
  logic [COUNT_W-1:0] words_r;
  status_t           status_r;
  logic              reply_disk_r;

  logic in_xfer, out_xfer, close_hdr;

  // The final header byte is taken only when the reply buffer is free.
  assign in_tready = !(phase_r == PH_H6 && out_valid_r);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign close_hdr = in_xfer && (phase_r == PH_H6);

  // --------------------------------------------------------------------------
  // Request decode, evaluated while the sixth header byte is on the input.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0]  func, baddr, sblock;
  logic               wr;
  logic [5:0]         pages;
  logic [COUNT_W-1:0] words;
  logic               present, rblk, wblk;
  logic               past_end, overlap;
  logic [WORD_W-1:0]  cdf_nxt, count_nxt, ack_nxt;
  logic [BLOCK_W-1:0] first_block_nxt;
  status_t            status_nxt;

  always_comb begin
    func   = {store_r[1], store_r[0]};
    baddr  = {store_r[3], store_r[2]};
    sblock = {in_tdata[HALF_W-1:0], store_r[4]};
    wr     = func[11];
    // A page field of zero stands for a full field of 32 pages.
    pages  = (func[10:6] == 5'd0) ? 6'd32 : {1'b0, func[10:6]};
    words  = COUNT_W'(pages) << PAGE_SHIFT;

    present = disk_r ? second_present_r : first_present_r;
    rblk    = disk_r ? second_rd_blk_r  : first_rd_blk_r;
    wblk    = disk_r ? second_wr_blk_r  : first_wr_blk_r;

    // Blocks hold two pages; an odd count still occupies a whole block.
    past_end = (BLOCK_W'(pages[5:1]) + BLOCK_W'(pages[0]) + BLOCK_W'(sblock))
               > BLOCK_W'(DISK_BLOCKS);
    overlap  = (func[5:3] == 3'd0) &&
               ((14'(baddr) + 14'(words)) > 14'(HANDLER_BASE));

    // The first failing check in the order below decides the answer.
    priority if (overlap) begin
      status_nxt = ST_OVERLAP;
      ack_nxt    = NAK_OVERLAP;
    end else if (past_end) begin
      status_nxt = ST_PAST_END;
      ack_nxt    = NAK_PAST_END;
    end else if ((!wr && rblk) || (wr && wblk)) begin
      status_nxt = ST_PROTECT;
      ack_nxt    = NAK_PROTECT;
    end else if (!present) begin
      status_nxt = ST_NO_DISK;
      ack_nxt    = NAK;
    end else begin
      status_nxt = ST_OK;
      ack_nxt    = wr ? ACK_WR : ACK_RD;
    end

    cdf_nxt         = CDF_BASE | (func & FIELD_MASK);
    count_nxt       = WORD_W'(COUNT_W'(0) - words);
    first_block_nxt = BLOCK_W'(sblock) + (side_r ? BLOCK_W'(DISK_BLOCKS) : BLOCK_W'(0));
  end

  // --------------------------------------------------------------------------
  // State, configuration and reply buffer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_CMD;
      disk_r           <= 1'b0;
      side_r           <= 1'b0;
      out_valid_r      <= 1'b0;
      slot_r           <= SLOT_CDF;
      first_present_r  <= 1'b1;
      second_present_r <= 1'b0;
      first_rd_blk_r   <= 1'b0;
      first_wr_blk_r   <= 1'b0;
      second_rd_blk_r  <= 1'b0;
      second_wr_blk_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FIRST_PRESENT:  first_present_r  <= cfg_data;
          CFG_SECOND_PRESENT: second_present_r <= cfg_data;
          CFG_FIRST_RD_BLK:   first_rd_blk_r   <= cfg_data;
          CFG_FIRST_WR_BLK:   first_wr_blk_r   <= cfg_data;
          CFG_SECOND_RD_BLK:  second_rd_blk_r  <= cfg_data;
          CFG_SECOND_WR_BLK:  second_wr_blk_r  <= cfg_data;
          default: ;
        endcase
      end

      if (in_xfer) begin
        unique case (phase_r)
          PH_CMD: begin
            if (in_tdata >= CMD_A && in_tdata <= CMD_D) begin
              disk_r  <= (in_tdata == CMD_C) || (in_tdata == CMD_D);
              side_r  <= (in_tdata == CMD_B) || (in_tdata == CMD_D);
              phase_r <= PH_H1;
            end
          end
          PH_H1: begin store_r[0] <= in_tdata[HALF_W-1:0]; phase_r <= PH_H2; end
          PH_H2: begin store_r[1] <= in_tdata[HALF_W-1:0]; phase_r <= PH_H3; end
          PH_H3: begin store_r[2] <= in_tdata[HALF_W-1:0]; phase_r <= PH_H4; end
          PH_H4: begin store_r[3] <= in_tdata[HALF_W-1:0]; phase_r <= PH_H5; end
          PH_H5: begin store_r[4] <= in_tdata[HALF_W-1:0]; phase_r <= PH_H6; end
          PH_H6: phase_r <= PH_CMD;
          default: phase_r <= PH_CMD;
        endcase
      end

      // A header can only close while the buffer is empty, so load and drain
      // never collide.
      if (close_hdr) begin
        out_valid_r <= 1'b1;
        slot_r      <= SLOT_CDF;
      end else if (out_xfer) begin
        if (slot_r == SLOT_ACK) begin
          out_valid_r <= 1'b0;
          slot_r      <= SLOT_CDF;
        end else begin
          slot_r <= slot_r + 2'd1;
        end
      end
    end
  end

  // Reply payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (close_hdr) begin
      cdf_r         <= cdf_nxt;
      count_r       <= count_nxt;
      ack_r         <= ack_nxt;
      wr_r          <= wr;
      pad_r         <= wr && pages[0];
      first_block_r <= first_block_nxt;
      words_r       <= words;
      status_r      <= status_nxt;
    end
  end

  // Disk choice as latched for the reply in flight.
  always_ff @(posedge clk) begin
    if (close_hdr) begin
      reply_disk_r <= disk_r;
    end
  end

  // --------------------------------------------------------------------------
  // Reply word selection; the descriptor appears only on the acknowledge.
  // --------------------------------------------------------------------------
  logic              last;
  logic [WORD_W-1:0] tx_word;

  always_comb begin
    last = (slot_r == SLOT_ACK);
    unique case (slot_r)
      SLOT_CDF:   tx_word = cdf_r;
      SLOT_COUNT: tx_word = count_r;
      default:    tx_word = ack_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last;
  assign out_tdata  = last ?
      {4'd0, status_r, pad_r, words_r, first_block_r, reply_disk_r, wr_r, tx_word} :
      {36'd0, tx_word};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_close_loads: assert property (@(posedge clk) disable iff (!rst_n)
    close_hdr |=> (out_valid_r && slot_r == SLOT_CDF))
    else $error("closed header did not load the reply buffer");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (slot_r != 2'd3))
    else $error("reply slot out of range");

  a_drain_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_xfer && slot_r == SLOT_ACK))
    else $error("reply buffer emptied before the acknowledge was sent");

  a_desc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[OUT_W-1:WORD_W] == '0))
    else $error("descriptor present on a non-final reply word");

endmodule
